>>> sv/crvs_pkg.sv
// Shared types and constants for the center-ray volume sampler.
package crvs_pkg;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_SLICE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_COL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SLICE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd6;

  // Query command handed from the front end to the sampler.
  typedef struct packed {
    logic [4:0] row;
    logic [4:0] col;
    logic [4:0] slice;
    logic       at_center;
    logic [6:0] count;
  } query_t;
endpackage

>>> sv/crvs_front.sv
// Front end: accepts items, performs voxel writes, queues masked queries.
module crvs_front
  import crvs_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int COLS = 32,
  parameter int SLICES = 32,
  parameter int MAX_SAMPLES = 64,
  parameter int AW = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [4:0]        voxel_row,
  input  logic [4:0]        voxel_col,
  input  logic [4:0]        voxel_slice,
  input  logic signed [15:0] voxel_value,
  input  logic              in_mask,
  input  logic [15:0]       center_row,
  input  logic [15:0]       center_col,
  input  logic [15:0]       center_slice,
  input  logic [6:0]        sample_count,
  input  logic              back_idle,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [15:0]       wr_data,
  output logic              q_valid,
  output query_t            q_data,
  input  logic              q_pop
);
  localparam int QD = 4;
  query_t     fifo [QD];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] fill;
  logic       acc, push, in_range;
  query_t     cmd;
  logic [6:0] cnt;

  // a write waits until every earlier query has read the store
  assign in_stall = (fill == 3'(QD)) ||
                    (!opcode && ((fill != 3'd0) || !back_idle));
  assign acc = in_valid && !in_stall;
  assign push = acc && opcode && in_mask;
  assign in_range = (32'(voxel_row) < ROWS) && (32'(voxel_col) < COLS) &&
                    (32'(voxel_slice) < SLICES);

  always_comb begin
    cnt = sample_count;
    if (cnt == 7'd0) cnt = 7'd1;
    if (32'(cnt) > MAX_SAMPLES) cnt = 7'(MAX_SAMPLES);
    cmd.row = voxel_row;
    cmd.col = voxel_col;
    cmd.slice = voxel_slice;
    cmd.count = cnt;
    cmd.at_center = (center_row == {3'd0, voxel_row, 8'd0}) &&
                    (center_col == {3'd0, voxel_col, 8'd0}) &&
                    (center_slice == {3'd0, voxel_slice, 8'd0});
  end

  always_ff @(posedge clk) begin
    wr_en <= acc && !opcode && in_range && !rst;
    wr_addr <= AW'((32'(voxel_row) * COLS + 32'(voxel_col)) * SLICES + 32'(voxel_slice));
    wr_data <= voxel_value;
    if (push) fifo[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (q_pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(q_pop);
    end
  end

  assign q_valid = (fill != 3'd0);
  assign q_data = fifo[rd_ptr];
endmodule

>>> sv/crvs_axis.sv
// One axis: sample coordinates for a step, pipelined multiply and round.
module crvs_axis #(
  parameter int DIM = 32,
  parameter int IW = 6
) (
  input  logic          clk,
  input  logic [4:0]    pos,
  input  logic [15:0]   center,
  input  logic [23:0]   scale,
  input  logic [5:0]    steps,
  output logic [IW-1:0] idx_in,
  output logic [IW-1:0] idx_out,
  output logic          ok_in,
  output logic          ok_out
);
  logic signed [17:0] diff;
  logic signed [42:0] prod1;
  logic signed [49:0] off;
  logic [4:0]         pos1, pos2;
  logic signed [51:0] vin, vout;
  logic signed [27:0] rin, rout;

  function automatic logic signed [27:0] rnd(input logic signed [51:0] v);
    logic [51:0] m;
    logic [51:0] t;
    begin
      m = v[51] ? 52'(-v) : 52'(v);
      t = (m + 52'(1 << 23)) >> 24;
      rnd = v[51] ? -28'(t) : 28'(t);
    end
  endfunction

  assign diff = $signed({2'b0, center}) - $signed({5'b0, pos, 8'd0});

  always_ff @(posedge clk) begin
    prod1 <= diff * $signed({1'b0, scale});
    pos1 <= pos;
    off <= prod1 * $signed({1'b0, steps});
    pos2 <= pos1;
  end

  assign vin  = $signed({23'd0, pos2, 24'd0}) + 52'(off);
  assign vout = $signed({23'd0, pos2, 24'd0}) - 52'(off);
  assign rin  = rnd(vin);
  assign rout = rnd(vout);

  always_ff @(posedge clk) begin
    ok_in  <= !rin[27] && (rin < 28'(DIM));
    ok_out <= !rout[27] && (rout < 28'(DIM));
    idx_in <= IW'(rin);
    idx_out <= IW'(rout);
  end
endmodule

>>> sv/crvs_back.sv
// Back end: steps through samples, reads the store, drives results.
module crvs_back
  import crvs_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int COLS = 32,
  parameter int SLICES = 32,
  parameter int AW = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  query_t            q_data,
  output logic              q_pop,
  output logic              idle,
  input  logic [15:0]       center_row,
  input  logic [15:0]       center_col,
  input  logic [15:0]       center_slice,
  input  logic [23:0]       step_scale_row,
  input  logic [23:0]       step_scale_col,
  input  logic [23:0]       step_scale_slice,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [15:0]       wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        sample_index,
  output logic signed [15:0] inward_value,
  output logic signed [15:0] outward_value,
  output logic              last
);
  localparam int RW = $clog2(ROWS) + 1;
  localparam int CW = $clog2(COLS) + 1;
  localparam int SW = $clog2(SLICES) + 1;
  localparam int LAT = 5;

  logic [15:0] mem_a [2**AW];
  logic [15:0] mem_b [2**AW];
  logic        busy;
  query_t      cur;
  logic [6:0]  step;
  logic [5:0]  step_q;
  logic [2:0]  infl;
  logic        issue;
  logic [LAT-1:0] v_pipe, l_pipe, z_pipe;
  logic [5:0]  s_pipe [LAT];
  logic [RW-1:0] ri, ro;
  logic [CW-1:0] ci, co;
  logic [SW-1:0] si, so;
  logic rki, rko, cki, cko, ski, sko;
  logic [15:0] rd_a, rd_b;
  logic ok_a, ok_b;
  logic        room;

  // one pair at a time: pipeline and output register must both be empty
  assign room = (infl == 3'd0) && !out_valid;
  assign issue = busy && room;
  assign q_pop = !busy && q_valid;
  assign idle = !busy && (infl == 3'd0);

  crvs_axis #(.DIM(ROWS), .IW(RW)) u_row (.clk, .pos(cur.row), .center(center_row),
    .scale(step_scale_row), .steps(step_q), .idx_in(ri), .idx_out(ro),
    .ok_in(rki), .ok_out(rko));
  crvs_axis #(.DIM(COLS), .IW(CW)) u_col (.clk, .pos(cur.col), .center(center_col),
    .scale(step_scale_col), .steps(step_q), .idx_in(ci), .idx_out(co),
    .ok_in(cki), .ok_out(cko));
  crvs_axis #(.DIM(SLICES), .IW(SW)) u_slc (.clk, .pos(cur.slice), .center(center_slice),
    .scale(step_scale_slice), .steps(step_q), .idx_in(si), .idx_out(so),
    .ok_in(ski), .ok_out(sko));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    rd_a <= mem_a[AW'((32'(ri) * COLS + 32'(ci)) * SLICES + 32'(si))];
    rd_b <= mem_b[AW'((32'(ro) * COLS + 32'(co)) * SLICES + 32'(so))];
    ok_a <= rki && cki && ski;
    ok_b <= rko && cko && sko;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      v_pipe <= '0;
      infl <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        cur <= q_data;
        step <= '0;
      end else if (issue) begin
        step <= step + 7'd1;
        if (step + 7'd1 == cur.count) busy <= 1'b0;
      end
      v_pipe <= {v_pipe[LAT-2:0], issue};
      infl <= infl + 3'(issue) - 3'(v_pipe[LAT-1]);
      if (v_pipe[LAT-1]) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) step_q <= step[5:0];
    l_pipe <= {l_pipe[LAT-2:0], (step + 7'd1 == cur.count)};
    z_pipe <= {z_pipe[LAT-2:0], cur.at_center};
    s_pipe[0] <= step[5:0];
    for (int k = 1; k < LAT; k++) s_pipe[k] <= s_pipe[k-1];
    if (v_pipe[LAT-1]) begin
      sample_index <= s_pipe[LAT-1];
      last <= l_pipe[LAT-1];
      inward_value <= (ok_a && !z_pipe[LAT-1]) ? rd_a : 16'sd0;
      outward_value <= (ok_b && !z_pipe[LAT-1]) ? rd_b : 16'sd0;
    end
  end
endmodule

>>> sv/center_ray_volume_sampler.sv
// Top level: center-ray volume sampler.
// Write items wait until every queued query has finished.
// A masked query emits sample_count pairs (zero is taken as one, capped at
// MAX_SAMPLES) one at a time: a pair issues only when the 5-stage index/read
// pipeline and the output register are empty. Synchronous rst clears control
// and the configuration registers; the voxel store is not cleared.
module center_ray_volume_sampler
  import crvs_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int COLS = 32,
  parameter int SLICES = 32,
  parameter int MAX_SAMPLES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [4:0]        voxel_row,
  input  logic [4:0]        voxel_col,
  input  logic [4:0]        voxel_slice,
  input  logic signed [15:0] voxel_value,
  input  logic              in_mask,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        sample_index,
  output logic signed [15:0] inward_value,
  output logic signed [15:0] outward_value,
  output logic              last
);
  localparam int AW = $clog2(ROWS * COLS * SLICES);
  logic [15:0] center_row, center_col, center_slice;
  logic [23:0] step_scale_row, step_scale_col, step_scale_slice;
  logic [6:0]  sample_count;
  logic        wr_en, q_valid, q_pop, back_idle;
  logic [AW-1:0] wr_addr;
  logic [15:0] wr_data;
  query_t      q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_row <= '0;
      center_col <= '0;
      center_slice <= '0;
      step_scale_row <= '0;
      step_scale_col <= '0;
      step_scale_slice <= '0;
      sample_count <= 7'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_ROW:   center_row <= cfg_data[15:0];
        REG_CENTER_COL:   center_col <= cfg_data[15:0];
        REG_CENTER_SLICE: center_slice <= cfg_data[15:0];
        REG_SCALE_ROW:    step_scale_row <= cfg_data;
        REG_SCALE_COL:    step_scale_col <= cfg_data;
        REG_SCALE_SLICE:  step_scale_slice <= cfg_data;
        REG_SAMPLE_COUNT: sample_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  crvs_front #(.ROWS(ROWS), .COLS(COLS), .SLICES(SLICES), .MAX_SAMPLES(MAX_SAMPLES),
    .AW(AW)) u_front (
    .clk, .rst, .in_valid, .in_stall, .opcode, .voxel_row, .voxel_col, .voxel_slice,
    .voxel_value, .in_mask, .center_row, .center_col, .center_slice, .sample_count,
    .back_idle, .wr_en, .wr_addr, .wr_data, .q_valid, .q_data, .q_pop);

  crvs_back #(.ROWS(ROWS), .COLS(COLS), .SLICES(SLICES), .AW(AW)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .idle(back_idle), .center_row, .center_col,
    .center_slice, .step_scale_row, .step_scale_col, .step_scale_slice, .wr_en,
    .wr_addr, .wr_data, .out_valid, .out_stall, .sample_index, .inward_value,
    .outward_value, .last);

`ifndef SYNTH
  a_pop_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_index))
    else $error("result dropped under stall");
`endif
endmodule
